@@ hdl/acc_pkg.sv @@
// shared types and constants for the alpha checkerboard composite unit
// no dependencies; imported by every module of the block

package acc_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_LANES   = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = NUM_LANES * CHAN_W;
    localparam int IMG_W_W     = 13;
    localparam int ROW_W       = 12;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [1:0] REG_LIGHT_GRAY  = 2'd1;
    localparam logic [1:0] REG_DARK_GRAY   = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 13'd640;
    localparam logic [CHAN_W-1:0]  LIGHT_GRAY_RST  = 8'd224;
    localparam logic [CHAN_W-1:0]  DARK_GRAY_RST   = 8'd192;

    localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE    = 8'd255;
    localparam logic [CHAN_W-1:0]  ALPHA_CLEAR     = 8'd0;

    // what the position tracker hands to the lanes for one pixel
    typedef struct packed {
        logic [CHAN_W-1:0] gray;
        logic              last;
    } pos_t;

endpackage

@@ hdl/alpha_checkerboard_composite_unit.sv @@
// alpha checkerboard composite: bgra stream in, bgr over a gray checkerboard out
// a pixel passes the stage 1 register, then the output register, on its way to m_tvalid;
// throughput one pixel per clock while m_tready is high, via the combinational blend lanes
// reset: counters at the origin, image_width 640, light gray 224, dark gray 192,
// both pipeline stages empty
// depends on acc_pkg, acc_position, acc_blend_lane, acc_merge

module alpha_checkerboard_composite_unit #(
    parameter int MAX_WIDTH = 4096,
    parameter int CELL_SIZE = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config port (apb style, pready tied high)
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acc_pkg::APB_AW-1:0]      paddr,
    input  logic [acc_pkg::APB_DW-1:0]      pwdata,
    output logic [acc_pkg::APB_DW-1:0]      prdata,
    output logic                            pready,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [acc_pkg::IN_TDATA_W-1:0]  s_tdata,  // blue_in, green_in, red_in, alpha_in
    input  logic                            s_tuser,  // start_of_frame
    // pixel output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [acc_pkg::OUT_TDATA_W-1:0] m_tdata,  // blue_out, green_out, red_out
    output logic                            m_tlast   // end_of_row
);
    import acc_pkg::*;

    // configuration registers
    logic [IMG_W_W-1:0] image_width_reg;
    logic [CHAN_W-1:0]  light_gray_reg;
    logic [CHAN_W-1:0]  dark_gray_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    // stage 1: accepted pixel with its gray level and row-end flag
    logic               s1_valid_reg, s1_valid_next;
    logic [CHAN_W-1:0]  s1_chan_reg [NUM_LANES];
    logic [CHAN_W-1:0]  s1_alpha_reg;
    pos_t               s1_pos_reg;

    logic               in_accept;
    logic               merge_ready;
    pos_t               pos;
    logic [CHAN_W-1:0]  lane_px [NUM_LANES];

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RST;
            light_gray_reg  <= LIGHT_GRAY_RST;
            dark_gray_reg   <= DARK_GRAY_RST;
        end
        else if (cfg_wr)
        begin
            // unknown register indexes are dropped
            unique case (cfg_idx)
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[IMG_W_W-1:0];
                REG_LIGHT_GRAY:  light_gray_reg  <= pwdata[CHAN_W-1:0];
                REG_DARK_GRAY:   dark_gray_reg   <= pwdata[CHAN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH: prdata = APB_DW'(image_width_reg);
            REG_LIGHT_GRAY:  prdata = APB_DW'(light_gray_reg);
            REG_DARK_GRAY:   prdata = APB_DW'(dark_gray_reg);
            default:         prdata = '0;
        endcase
    end

    // stage 1 holds a pixel until the output stage can take it; a new pixel
    // enters in the same cycle the held one moves on
    assign s_tready  = !s1_valid_reg || merge_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (merge_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    // position tracker sees the pixel in its accept cycle
    acc_position #(
        .MAX_WIDTH (MAX_WIDTH),
        .CELL_SIZE (CELL_SIZE)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .sof         (s_tuser),
        .image_width (image_width_reg),
        .light_gray  (light_gray_reg),
        .dark_gray   (dark_gray_reg),
        .pos         (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < NUM_LANES; i++)
                s1_chan_reg[i] <= s_tdata[i*CHAN_W +: CHAN_W];
            s1_alpha_reg <= s_tdata[NUM_LANES*CHAN_W +: CHAN_W];
            s1_pos_reg   <= pos;
        end
    end

    // one blend lane per color channel (blue, green, red), all sharing alpha and gray
    for (genvar gi = 0; gi < NUM_LANES; gi++)
    begin : g_lane
        acc_blend_lane u_lane (
            .color  (s1_chan_reg[gi]),
            .alpha  (s1_alpha_reg),
            .gray   (s1_pos_reg.gray),
            .result (lane_px[gi])
        );
    end

    // merge the lane results into the registered output transaction
    acc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid_reg),
        .load_ready (merge_ready),
        .lane_px    (lane_px),
        .lane_last  (s1_pos_reg.last),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ hdl/acc_position.sv @@
// raster position tracker: column/row counters and checkerboard cell parity
// depends on acc_pkg

module acc_position #(
    parameter int MAX_WIDTH = 4096,
    parameter int CELL_SIZE = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          sof,
    input  logic [acc_pkg::IMG_W_W-1:0]   image_width,
    input  logic [acc_pkg::CHAN_W-1:0]    light_gray,
    input  logic [acc_pkg::CHAN_W-1:0]    dark_gray,
    output acc_pkg::pos_t                 pos
);
    import acc_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W  = (COL_W + 1 > IMG_W_W + 1) ? COL_W + 1 : IMG_W_W + 1;
    localparam int CELL_W = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;
    localparam logic [CMP_W-1:0]  MAX_W_C   = CMP_W'(MAX_WIDTH);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_SIZE - 1);

    logic [COL_W-1:0]  col_reg, col_next, col_eff;
    logic [ROW_W-1:0]  row_reg, row_next, row_eff;
    logic [CELL_W-1:0] col_sub_reg, col_sub_next, col_sub_eff;
    logic [CELL_W-1:0] row_sub_reg, row_sub_next, row_sub_eff;
    logic              col_par_reg, col_par_next, col_par_eff;
    logic              row_par_reg, row_par_next, row_par_eff;
    logic [CMP_W-1:0]  iw_ext, eff_width, col_plus;
    logic              last;

    always_comb
    begin
        // start of frame puts this pixel at the origin
        col_eff     = sof ? '0 : col_reg;
        row_eff     = sof ? '0 : row_reg;
        col_sub_eff = sof ? '0 : col_sub_reg;
        row_sub_eff = sof ? '0 : row_sub_reg;
        col_par_eff = sof ? 1'b0 : col_par_reg;
        row_par_eff = sof ? 1'b0 : row_par_reg;

        iw_ext = CMP_W'(image_width);
        if (iw_ext == '0)
            eff_width = CMP_W'(1);
        else if (iw_ext > MAX_W_C)
            eff_width = MAX_W_C;
        else
            eff_width = iw_ext;

        col_plus = CMP_W'(col_eff) + CMP_W'(1);
        last     = (col_plus >= eff_width);

        pos.gray = (col_par_eff ^ row_par_eff) ? dark_gray : light_gray;
        pos.last = last;

        if (last)
        begin
            col_next     = '0;
            col_sub_next = '0;
            col_par_next = 1'b0;
            row_next     = row_eff + ROW_W'(1);
            if (&row_eff)
            begin
                // row count wraps, parity restarts with it
                row_sub_next = '0;
                row_par_next = 1'b0;
            end
            else if (row_sub_eff == CELL_LAST)
            begin
                row_sub_next = '0;
                row_par_next = ~row_par_eff;
            end
            else
            begin
                row_sub_next = row_sub_eff + CELL_W'(1);
                row_par_next = row_par_eff;
            end
        end
        else
        begin
            col_next     = col_eff + COL_W'(1);
            row_next     = row_eff;
            row_sub_next = row_sub_eff;
            row_par_next = row_par_eff;
            if (col_sub_eff == CELL_LAST)
            begin
                col_sub_next = '0;
                col_par_next = ~col_par_eff;
            end
            else
            begin
                col_sub_next = col_sub_eff + CELL_W'(1);
                col_par_next = col_par_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_sub_reg <= '0;
            row_sub_reg <= '0;
            col_par_reg <= 1'b0;
            row_par_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            col_sub_reg <= col_sub_next;
            row_sub_reg <= row_sub_next;
            col_par_reg <= col_par_next;
            row_par_reg <= row_par_next;
        end
    end

endmodule

@@ hdl/acc_blend_lane.sv @@
// one color channel lane: alpha blend against the cell gray, divide by 255 rounded
// depends on acc_pkg

module acc_blend_lane (
    input  logic [acc_pkg::CHAN_W-1:0] color,
    input  logic [acc_pkg::CHAN_W-1:0] alpha,
    input  logic [acc_pkg::CHAN_W-1:0] gray,
    output logic [acc_pkg::CHAN_W-1:0] result
);
    import acc_pkg::*;

    logic [2*CHAN_W-1:0] prod_c, prod_g;
    logic [2*CHAN_W:0]   v, rounded;
    logic [CHAN_W-1:0]   inv_alpha;

    always_comb
    begin
        inv_alpha = ALPHA_OPAQUE - alpha;
        prod_c    = color * alpha;
        prod_g    = gray * inv_alpha;
        v         = {1'b0, prod_c} + {1'b0, prod_g};
        // (v + 128 + (v >> 8)) >> 8 approximates v / 255 rounded
        rounded   = v + (2*CHAN_W+1)'(128) + (v >> CHAN_W);

        if (alpha == ALPHA_OPAQUE)
            result = color;
        else if (alpha == ALPHA_CLEAR)
            result = gray;
        else
            result = rounded[2*CHAN_W-1:CHAN_W];
    end

endmodule

@@ hdl/acc_merge.sv @@
// output stage: gathers the lane results into one registered bgr transaction
// depends on acc_pkg

module acc_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load_valid,
    output logic                            load_ready,
    input  logic [acc_pkg::CHAN_W-1:0]      lane_px [acc_pkg::NUM_LANES],
    input  logic                            lane_last,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [acc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import acc_pkg::*;

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic                   last_reg;
    logic                   load;

    always_comb
    begin
        load_ready = !valid_reg || m_tready;
        load       = load_valid && load_ready;
        for (int i = 0; i < NUM_LANES; i++)
            data_next[i*CHAN_W +: CHAN_W] = lane_px[i];
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
            last_reg <= lane_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule
